// ===== hw/rtl/cantxs_pkg.sv =====
// Shared types and constants for the CAN transmit buffer scheduler.
`timescale 1ns / 1ps

package cantxs_pkg;

    localparam int IDX_W  = 5;
    localparam int CNT_W  = 8;
    localparam int POP_W  = 6;
    localparam int OP_W   = 2;
    localparam int PC_W   = 2;
    localparam int MASK_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_SEND  = 2'd0,
        OP_DONE  = 2'd1,
        OP_PURGE = 2'd2
    } opcode_t;

    typedef enum logic [PC_W-1:0] {
        PURGE_NONE      = 2'd0,
        PURGE_IN_FLIGHT = 2'd1,
        PURGE_PENDING   = 2'd2
    } purge_code_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] low_idx;
        logic [POP_W-1:0] drop_cnt;
    } scan_t;

    typedef struct packed {
        logic             issue_valid;
        logic [IDX_W-1:0] issue_index;
        logic             overflow_seen;
        logic             overflow_report;
        purge_code_t      purge_code;
    } result_t;

endpackage

// ===== hw/rtl/cantxs_scan.sv =====
// Lowest pending buffer search and count of sync buffers to drop.
`timescale 1ns / 1ps

module cantxs_scan
    import cantxs_pkg::*;
#(
    parameter int NUM_TX_BUFFERS = 32
)
(
    input  logic [NUM_TX_BUFFERS-1:0] live,
    input  logic [NUM_TX_BUFFERS-1:0] drop,
    output scan_t                     scan
);

    always_comb
    begin
        scan = '0;
        for (int i = NUM_TX_BUFFERS - 1; i >= 0; i--)
        begin
            if (live[i])
            begin
                scan.found   = 1'b1;
                scan.low_idx = IDX_W'(i);
            end
        end
        for (int i = 0; i < NUM_TX_BUFFERS; i++)
        begin
            scan.drop_cnt = scan.drop_cnt + POP_W'(drop[i]);
        end
    end

endmodule

// ===== hw/rtl/cantxs_sched.sv =====
// Scheduler state and request update logic.
`timescale 1ns / 1ps

module cantxs_sched
    import cantxs_pkg::*;
#(
    parameter int NUM_TX_BUFFERS = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  logic [OP_W-1:0]   opcode,
    input  logic [IDX_W-1:0]  buffer_index,
    input  logic [MASK_W-1:0] sync_mask,
    output result_t           result
);

    logic [NUM_TX_BUFFERS-1:0] pending_reg, pending_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      sync_in_flight_reg, sync_in_flight_next;
    logic                      bootup_unsent_reg, bootup_unsent_next;

    logic [NUM_TX_BUFFERS-1:0] sync_vec;
    logic [NUM_TX_BUFFERS-1:0] req_bit;
    logic [NUM_TX_BUFFERS-1:0] low_onehot;
    logic [NUM_TX_BUFFERS-1:0] drop;
    logic                      in_range;
    logic                      cnt_zero;
    scan_t                     scan;

    assign sync_vec   = sync_mask[NUM_TX_BUFFERS-1:0];
    assign in_range   = {1'b0, buffer_index} < (IDX_W + 1)'(NUM_TX_BUFFERS);
    assign req_bit    = in_range ? (NUM_TX_BUFFERS'(1) << buffer_index) : '0;
    assign low_onehot = pending_reg & (~pending_reg + NUM_TX_BUFFERS'(1));
    assign drop       = pending_reg & sync_vec;
    assign cnt_zero   = (count_reg == '0);

    cantxs_scan #(
        .NUM_TX_BUFFERS(NUM_TX_BUFFERS)
    ) u_scan (
        .live(pending_reg),
        .drop(drop),
        .scan(scan)
    );

    always_comb
    begin
        pending_next        = pending_reg;
        count_next          = count_reg;
        sync_in_flight_next = sync_in_flight_reg;
        bootup_unsent_next  = bootup_unsent_reg;
        result              = '0;
        result.purge_code   = PURGE_NONE;

        unique case (opcode)
            OP_SEND:
            begin
                if (in_range)
                begin
                    result.overflow_seen   = |(pending_reg & req_bit);
                    result.overflow_report = result.overflow_seen & ~bootup_unsent_reg;
                    if (cnt_zero)
                    begin
                        sync_in_flight_next = |(req_bit & sync_vec);
                        result.issue_valid  = 1'b1;
                        result.issue_index  = buffer_index;
                    end
                    else
                    begin
                        pending_next = pending_reg | req_bit;
                        count_next   = (count_reg == {CNT_W{1'b1}}) ? count_reg
                                                                   : count_reg + 1'b1;
                    end
                end
            end
            OP_DONE:
            begin
                bootup_unsent_next  = 1'b0;
                sync_in_flight_next = 1'b0;
                if (!cnt_zero)
                begin
                    if (scan.found)
                    begin
                        pending_next        = pending_reg & ~low_onehot;
                        count_next          = count_reg - 1'b1;
                        sync_in_flight_next = |(low_onehot & sync_vec);
                        result.issue_valid  = 1'b1;
                        result.issue_index  = scan.low_idx;
                    end
                    else
                    begin
                        count_next = '0;
                    end
                end
            end
            OP_PURGE:
            begin
                if (sync_in_flight_reg)
                begin
                    sync_in_flight_next = 1'b0;
                    result.purge_code   = PURGE_IN_FLIGHT;
                end
                if (!cnt_zero && (drop != '0))
                begin
                    pending_next      = pending_reg & ~drop;
                    count_next        = (count_reg > CNT_W'(scan.drop_cnt))
                                        ? count_reg - CNT_W'(scan.drop_cnt) : '0;
                    result.purge_code = PURGE_PENDING;
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg        <= '0;
            count_reg          <= '0;
            sync_in_flight_reg <= 1'b0;
            bootup_unsent_reg  <= 1'b1;
        end
        else if (step_en)
        begin
            pending_reg        <= pending_next;
            count_reg          <= count_next;
            sync_in_flight_reg <= sync_in_flight_next;
            bootup_unsent_reg  <= bootup_unsent_next;
        end
    end

`ifndef SYNTHESIS
    // every queued buffer is covered by the count
    a_pending_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg != '0) |-> (count_reg != '0))
        else $error("pending buffer with zero count");

    a_bootup_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && opcode == OP_DONE) |=> !bootup_unsent_reg)
        else $error("bootup flag survived transmit complete");
`endif

endmodule

// ===== hw/rtl/can_tx_buffer_scheduler_unit.sv =====
// Top level of the CAN transmit buffer scheduler.
`timescale 1ns / 1ps

// Takes one request per cycle (send, transmit complete, purge) while the result
// side is not stalled; returns exactly one result per request, in order. A request
// is first captured in an input register; once the result register is free, the
// pending set, pending count and flags are updated and the result register is
// loaded. sync_buffer_mask resets to zero. The rate is set by the pending-state
// update with its priority encoder and drop count. The user must write the mask
// through cfg_wr_en only while no request is in progress; it is not enforced.

module can_tx_buffer_scheduler_unit
    import cantxs_pkg::*;
#(
    parameter int NUM_TX_BUFFERS = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [MASK_W-1:0] sync_buffer_mask,
    input  logic              req_valid,
    output logic              req_ready,
    input  logic [OP_W-1:0]   opcode,
    input  logic [IDX_W-1:0]  buffer_index,
    output logic              res_valid,
    input  logic              res_ready,
    output logic              issue_valid,
    output logic [IDX_W-1:0]  issue_index,
    output logic              overflow_seen,
    output logic              overflow_report,
    output logic [PC_W-1:0]   purge_code
);

    logic [MASK_W-1:0] sync_mask_reg;
    logic              in_valid_reg;
    logic [OP_W-1:0]   opcode_reg;
    logic [IDX_W-1:0]  index_reg;
    logic              res_valid_reg;
    result_t           res_reg;
    result_t           step_result;
    logic              advance;

    assign advance   = in_valid_reg && (!res_valid_reg || res_ready);
    assign req_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_mask_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            sync_mask_reg <= sync_buffer_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                in_valid_reg <= req_valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            opcode_reg <= opcode;
            index_reg  <= buffer_index;
        end
        if (advance)
        begin
            res_reg <= step_result;
        end
    end

    cantxs_sched #(
        .NUM_TX_BUFFERS(NUM_TX_BUFFERS)
    ) u_sched (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (advance),
        .opcode      (opcode_reg),
        .buffer_index(index_reg),
        .sync_mask   (sync_mask_reg),
        .result      (step_result)
    );

    assign res_valid       = res_valid_reg;
    assign issue_valid     = res_reg.issue_valid;
    assign issue_index     = res_reg.issue_index;
    assign overflow_seen   = res_reg.overflow_seen;
    assign overflow_report = res_reg.overflow_report;
    assign purge_code      = res_reg.purge_code;

`ifndef SYNTHESIS
    a_report_needs_seen: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (!res_reg.overflow_report || res_reg.overflow_seen))
        else $error("overflow reported without overflow");

    a_purge_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.purge_code != PURGE_NONE)
            |-> (!res_reg.issue_valid && !res_reg.overflow_seen))
        else $error("purge result mixed with issue or overflow");

    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_reg.issue_valid) |-> (res_reg.issue_index == '0))
        else $error("issue index set without issue");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("request dropped from input register");
`endif

endmodule
